>>> sv/configurable_crc_byte_engine_macros.svh
// assertion macros used by the top level of the crc engine
// no dependencies; expects clk and rst_n in the scope of use
`ifndef CONFIGURABLE_CRC_BYTE_ENGINE_MACROS_SVH
`define CONFIGURABLE_CRC_BYTE_ENGINE_MACROS_SVH

// checked only while out of reset
`define CCE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define CCE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/cce_pkg.sv
// shared types, constants and helper functions for the crc byte engine
// no dependencies
package cce_pkg;

  localparam int MAX_CRC_WIDTH = 32;
  localparam int CRC_W         = MAX_CRC_WIDTH;
  localparam int BYTE_W        = 8;
  localparam int CFG_IDX_W     = 3;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH_SEL   = 3'd0,
    CFG_GEN_POLY    = 3'd1,
    CFG_START_VALUE = 3'd2,
    CFG_REFLECT_IN  = 3'd3,
    CFG_REFLECT_OUT = 3'd4,
    CFG_INVERT_OUT  = 3'd5
  } cfg_idx_t;

  // width codes
  localparam logic [1:0] WSEL_8  = 2'd0;
  localparam logic [1:0] WSEL_16 = 2'd1;
  localparam logic [1:0] WSEL_32 = 2'd2;

  localparam logic [1:0]       RST_WIDTH_SEL = WSEL_32;
  localparam logic [CRC_W-1:0] RST_GEN_POLY  = 32'h04C1_1DB7;
  localparam logic [CRC_W-1:0] RST_START     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]       width_sel;
    logic [CRC_W-1:0] gen_poly;
    logic [CRC_W-1:0] start_value;
    logic             reflect_in;
    logic             reflect_out;
    logic             invert_out;
  } cce_cfg_t;

  // move a value of the selected width up to the top of the register;
  // bits above the width fall off, so this also masks
  function automatic logic [CRC_W-1:0] align_top(logic [CRC_W-1:0] v, logic [1:0] wsel);
    logic [CRC_W-1:0] r;
    case (wsel)
      WSEL_8:  r = v << (CRC_W - 8);
      WSEL_16: r = v << (CRC_W - 16);
      default: r = v;
    endcase
    return r;
  endfunction

  // inverse of align_top
  function automatic logic [CRC_W-1:0] align_low(logic [CRC_W-1:0] v, logic [1:0] wsel);
    logic [CRC_W-1:0] r;
    case (wsel)
      WSEL_8:  r = v >> (CRC_W - 8);
      WSEL_16: r = v >> (CRC_W - 16);
      default: r = v;
    endcase
    return r;
  endfunction

  // ones over the selected width, low aligned
  function automatic logic [CRC_W-1:0] width_mask(logic [1:0] wsel);
    return align_low({CRC_W{1'b1}}, wsel);
  endfunction

  function automatic logic [BYTE_W-1:0] rev_byte(logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] r;
    for (int i = 0; i < BYTE_W; i++) r[i] = v[BYTE_W-1-i];
    return r;
  endfunction

  function automatic logic [CRC_W-1:0] rev_word(logic [CRC_W-1:0] v);
    logic [CRC_W-1:0] r;
    for (int i = 0; i < CRC_W; i++) r[i] = v[CRC_W-1-i];
    return r;
  endfunction

endpackage

>>> sv/cce_cfg.sv
// configuration registers of the crc engine, with a reload request
// depends on cce_pkg
module cce_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [cce_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [cce_pkg::CRC_W-1:0]   cfg_wdata,
  output cce_pkg::cce_cfg_t           cfg_o,
  output logic                        reload_o
);
  import cce_pkg::*;

  cce_cfg_t cfg_r, cfg_nxt;
  logic     reload_r, reload_nxt;

  always_comb begin
    cfg_nxt    = cfg_r;
    reload_nxt = 1'b0;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_WIDTH_SEL: begin
          cfg_nxt.width_sel = cfg_wdata[1:0];
          reload_nxt        = 1'b1;
        end
        CFG_GEN_POLY: begin
          cfg_nxt.gen_poly = cfg_wdata;
        end
        CFG_START_VALUE: begin
          cfg_nxt.start_value = cfg_wdata;
          reload_nxt          = 1'b1;
        end
        CFG_REFLECT_IN: begin
          cfg_nxt.reflect_in = cfg_wdata[0];
        end
        CFG_REFLECT_OUT: begin
          cfg_nxt.reflect_out = cfg_wdata[0];
        end
        CFG_INVERT_OUT: begin
          cfg_nxt.invert_out = cfg_wdata[0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width_sel   <= RST_WIDTH_SEL;
      cfg_r.gen_poly    <= RST_GEN_POLY;
      cfg_r.start_value <= RST_START;
      cfg_r.reflect_in  <= 1'b0;
      cfg_r.reflect_out <= 1'b0;
      cfg_r.invert_out  <= 1'b0;
      reload_r          <= 1'b0;
    end else begin
      cfg_r    <= cfg_nxt;
      reload_r <= reload_nxt;
    end
  end

  assign cfg_o    = cfg_r;
  assign reload_o = reload_r;

endmodule

>>> sv/cce_fold.sv
// folds one message byte into the top-aligned crc register
// depends on cce_pkg
module cce_fold (
  input  logic [cce_pkg::CRC_W-1:0]  crc_i,
  input  logic [cce_pkg::BYTE_W-1:0] byte_i,
  input  cce_pkg::cce_cfg_t          cfg_i,
  output logic [cce_pkg::CRC_W-1:0]  crc_o
);
  import cce_pkg::*;

  logic [BYTE_W-1:0] in_byte;
  logic [CRC_W-1:0]  poly_al;
  logic [CRC_W-1:0]  entry;

  assign in_byte = cfg_i.reflect_in ? rev_byte(byte_i) : byte_i;
  // aligning the polynomial drops the bits above the width
  assign poly_al = align_top(cfg_i.gen_poly, cfg_i.width_sel);

  // table entry for the top byte, worked out bit by bit
  always_comb begin
    entry = {crc_i[CRC_W-1 -: BYTE_W] ^ in_byte, {(CRC_W-BYTE_W){1'b0}}};
    for (int k = 0; k < BYTE_W; k++) begin
      entry = entry[CRC_W-1] ? ((entry << 1) ^ poly_al) : (entry << 1);
    end
  end

  assign crc_o = entry ^ (crc_i << BYTE_W);

endmodule

>>> sv/cce_finish.sv
// turns the top-aligned crc register into the delivered result
// depends on cce_pkg
module cce_finish (
  input  logic [cce_pkg::CRC_W-1:0] crc_i,
  input  cce_pkg::cce_cfg_t         cfg_i,
  output logic [cce_pkg::CRC_W-1:0] result_o
);
  import cce_pkg::*;

  logic [CRC_W-1:0] plain;

  // reversing the whole aligned word reflects over the width and lands low
  assign plain    = cfg_i.reflect_out ? rev_word(crc_i) : align_low(crc_i, cfg_i.width_sel);
  assign result_o = cfg_i.invert_out ? (plain ^ width_mask(cfg_i.width_sel)) : plain;

endmodule

>>> sv/configurable_crc_byte_engine.sv
// top level of the configurable crc-8/16/32 byte engine
// depends on cce_pkg, cce_cfg, cce_fold, cce_finish and the macros header
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------
//  in      | in_tvalid/tready   | tdata[7:0] data_byte, tlast last_byte
//  out     | out_tvalid/tready  | tdata[31:0] crc_result
//  cfg     | cfg_we             | cfg_idx register index, cfg_wdata value
//
// one byte per cycle unless stalled: an item is held in the input register, then
// the byte fold updates the crc register, or a last byte loads the result register
// and restarts the crc. rst_n is synchronous; a width or start write sets a
// registered reload request, which loads the start value into the crc. only a last
// byte waiting on a full, undrained result register stalls the input.
`include "configurable_crc_byte_engine_macros.svh"

module configurable_crc_byte_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] data_byte
  input  logic                          in_tlast,   // last_byte
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata,  // [31:0] crc_result
  input  logic                          cfg_we,
  input  logic [cce_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [cce_pkg::CRC_W-1:0]     cfg_wdata
);
  import cce_pkg::*;

  cce_cfg_t cfg;
  logic     reload;

  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;
  logic              s1_fire;
  logic              in_fire;

  logic [CRC_W-1:0] crc_r, crc_nxt;
  logic [CRC_W-1:0] crc_fold;
  logic [CRC_W-1:0] start_al;
  logic [CRC_W-1:0] result;

  logic             out_valid_r, out_valid_nxt;
  logic [CRC_W-1:0] out_data_r;
  logic             out_load;

  cce_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .cfg_o    (cfg),
    .reload_o (reload)
  );

  cce_fold u_fold (
    .crc_i (crc_r),
    .byte_i(s1_byte_r),
    .cfg_i (cfg),
    .crc_o (crc_fold)
  );

  cce_finish u_finish (
    .crc_i   (crc_fold),
    .cfg_i   (cfg),
    .result_o(result)
  );

  assign start_al = align_top(cfg.start_value, cfg.width_sel);

  // a last item may only move on when the result register can take it
  assign s1_fire   = s1_valid_r && !(s1_last_r && out_valid_r && !out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = s1_fire && s1_last_r;

  always_comb begin
    s1_valid_nxt = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);

    crc_nxt = crc_r;
    if (reload) begin
      crc_nxt = start_al;
    end else if (s1_fire) begin
      crc_nxt = s1_last_r ? start_al : crc_fold;
    end

    out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      crc_r       <= RST_START;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      crc_r       <= crc_nxt;
    end
    if (in_fire) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (out_load) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // bits below the selected width stay clear in the aligned register,
  // except in the cycle between a width write and its reload
  `CCE_ASSERT(a_crc_low_clear, !reload |-> ((crc_r & ~align_top({CRC_W{1'b1}}, cfg.width_sel)) == '0), "crc register has bits below the width")
  // a waiting last item with a blocked result register holds the input
  `CCE_ASSERT(a_stall_back, (s1_valid_r && s1_last_r && out_valid_r && !out_tready) |-> !in_tready, "input taken while result path is blocked")
  // after a message ends the register restarts from the start value
  `CCE_ASSERT(a_restart, (out_load && !reload && !cfg_we) |=> (crc_r == $past(start_al)), "crc register not reloaded after last item")
  // a new result only ever follows a last item
  `CCE_ASSERT(a_result_src, $rose(out_tvalid) |-> $past(out_load), "result without a last item")

endmodule
